// ----- rtl/mrt_pkg.sv -----
// Shared types, constants and register codes for the median RTD temperature block.
// Used by every module of the block; it depends on nothing.
package mrt_pkg;

    localparam int WINDOW   = 5;
    localparam int POS_W    = $clog2(WINDOW);
    localparam int RANK_W   = $clog2(WINDOW);
    localparam int MED_RANK = WINDOW / 2;

    typedef logic signed [15:0] t_code;
    typedef logic signed [23:0] t_volt;
    typedef logic signed [19:0] t_res;
    typedef logic signed [21:0] t_temp;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RES_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_R_ZERO     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_SENS   = 3'd4;

    typedef struct packed {
        logic [22:0]        full_scale_uv;
        logic [23:0]        res_gain_q16;
        logic signed [17:0] res_offset_mohm;
        logic [19:0]        r_zero_mohm;
        logic [23:0]        inv_sens_q16;
    } t_cfg;

    localparam logic [22:0]        RST_FULL_SCALE = 23'd4096000;
    localparam logic [23:0]        RST_RES_GAIN   = 24'd3134144;
    localparam logic signed [17:0] RST_RES_OFFSET = -18'sd10;
    localparam logic [19:0]        RST_R_ZERO     = 20'd100000;
    localparam logic [23:0]        RST_INV_SENS   = 24'd170199;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int RES_DIVISOR = 1000;
    localparam int QUO_W       = 20;
    localparam int REM_W       = 31;

    // Rounded-up reciprocal of 1000 scaled by 2^38.
    localparam logic [28:0] RES_RECIP       = 29'd274877907;
    localparam int          RES_RECIP_SHIFT = 38;

    localparam int PRE_CLAMP = 500000000;
    localparam int PRE_QUO   = PRE_CLAMP / RES_DIVISOR;
    localparam int RES_MAX   = 300000;
    localparam int TEMP_MAX  = 2000000;

endpackage

// ----- rtl/mrt_fifo.sv -----
// Short queue of median codes between the front end and the arithmetic back end.
// Depends on mrt_pkg.
module mrt_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mrt_pkg::t_code i_push_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_avail,
    output mrt_pkg::t_code o_pop_data
);
    import mrt_pkg::*;

    t_code             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full     = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_avail    = (r_cnt != '0);
    assign o_pop_data = r_mem[r_rd];
    assign w_do_push  = i_push && !o_full;
    assign w_do_pop   = i_pop && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/mrt_front.sv -----
// Front end: sample ring, rank-based median search over the ring, push into the queue.
// Depends on mrt_pkg.
module mrt_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  mrt_pkg::t_code i_raw_code,
    output logic           o_push,
    output mrt_pkg::t_code o_push_data,
    input  logic           i_full
);
    import mrt_pkg::*;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } t_fstate;

    t_fstate           r_state;
    t_code             r_ring [WINDOW];
    logic [POS_W-1:0]  r_wpos;
    logic [POS_W-1:0]  r_idx;
    t_code             r_med;
    t_code             w_cand;
    logic [RANK_W-1:0] w_rank;

    assign o_stall     = (r_state != F_IDLE);
    assign o_push      = (r_state == F_PUSH);
    assign o_push_data = r_med;

    // The rank of an element counts smaller elements and equal ones stored before it.
    always_comb begin
        w_cand = r_ring[r_idx];
        w_rank = '0;
        for (int j = 0; j < WINDOW; j++) begin
            if ((r_ring[j] < w_cand) || ((r_ring[j] == w_cand) && (POS_W'(j) < r_idx))) begin
                w_rank = w_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_wpos  <= '0;
            r_idx   <= '0;
            for (int k = 0; k < WINDOW; k++) begin
                r_ring[k] <= '0;
            end
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_valid) begin
                        r_ring[r_wpos] <= i_raw_code;
                        r_wpos  <= (r_wpos == POS_W'(WINDOW - 1)) ? '0 : r_wpos + 1'b1;
                        r_idx   <= '0;
                        r_state <= F_SCAN;
                    end
                end
                F_SCAN: begin
                    if (w_rank == RANK_W'(MED_RANK)) begin
                        r_med <= w_cand;
                    end
                    if (r_idx == POS_W'(WINDOW - 1)) begin
                        r_state <= F_PUSH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/mrt_back.sv -----
// Back end: sequencer around one shared signed multiplier and a reciprocal division by 1000,
// producing voltage, resistance and temperature into the output register. Depends on mrt_pkg.
module mrt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrt_pkg::t_cfg  i_cfg,
    input  logic           i_q_avail,
    input  mrt_pkg::t_code i_q_data,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output mrt_pkg::t_code o_median_code,
    output mrt_pkg::t_volt o_voltage_uv,
    output mrt_pkg::t_res  o_resistance_mohm,
    output mrt_pkg::t_temp o_temperature_mdeg
);
    import mrt_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MUL_V,
        B_VOLT,
        B_MUL_R,
        B_SCALE,
        B_DIV,
        B_RES,
        B_MUL_T,
        B_TEMP
    } t_bstate;

    t_bstate               r_state;
    t_code                 r_med;
    t_volt                 r_volt;
    t_res                  r_res;
    logic signed [48:0]    r_prod;
    logic [REM_W-1:0]      r_rem;
    logic [QUO_W-1:0]      r_quo;
    logic                  r_out_valid;
    t_code                 r_out_med;
    t_volt                 r_out_volt;
    t_res                  r_out_res;
    t_temp                 r_out_temp;

    logic signed [24:0]    w_mul_a;
    logic signed [24:0]    w_mul_b;
    logic signed [49:0]    w_prod;
    logic signed [21:0]    w_diff;
    logic signed [48:0]    w_vsum;
    logic signed [48:0]    w_ssum;
    logic signed [32:0]    w_q1;
    logic signed [32:0]    w_q1c;
    logic signed [32:0]    w_bias;
    logic [59:0]           w_recip_prod;
    logic signed [22:0]    w_rsum;
    logic signed [22:0]    w_rclamp;
    logic signed [48:0]    w_tsum;
    logic signed [32:0]    w_t;
    logic signed [32:0]    w_tclamp;

    assign o_q_pop            = (r_state == B_IDLE) && i_q_avail;
    assign o_valid            = r_out_valid;
    assign o_median_code      = r_out_med;
    assign o_voltage_uv       = r_out_volt;
    assign o_resistance_mohm  = r_out_res;
    assign o_temperature_mdeg = r_out_temp;

    assign w_diff = {{2{r_res[19]}}, r_res} - {2'b00, i_cfg.r_zero_mohm};

    always_comb begin
        case (r_state)
            B_MUL_V: begin
                w_mul_a = {{9{r_med[15]}}, r_med};
                w_mul_b = {2'b00, i_cfg.full_scale_uv};
            end
            B_MUL_R: begin
                w_mul_a = {r_volt[23], r_volt};
                w_mul_b = {1'b0, i_cfg.res_gain_q16};
            end
            B_MUL_T: begin
                w_mul_a = {{3{w_diff[21]}}, w_diff};
                w_mul_b = {1'b0, i_cfg.inv_sens_q16};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Voltage: round half up of product / 2^15.
    assign w_vsum = r_prod + 49'sd16384;

    // Resistance: floor((p + 32768000) / 2^16) then floor divide by 1000. The first quotient
    // is clamped where the result saturates anyway, then biased to be nonnegative.
    assign w_ssum = r_prod + 49'sd32768000;
    assign w_q1   = w_ssum[48:16];

    always_comb begin
        if (w_q1 > 33'sd500000000) begin
            w_q1c = 33'sd500000000;
        end else if (w_q1 < -33'sd500000000) begin
            w_q1c = -33'sd500000000;
        end else begin
            w_q1c = w_q1;
        end
    end

    assign w_bias = w_q1c + 33'(PRE_CLAMP);

    // The reciprocal product gives the exact quotient for any dividend below 2^32.
    assign w_recip_prod = r_rem * RES_RECIP;

    assign w_rsum = {3'b000, r_quo} - 23'(PRE_QUO)
                  + {{5{i_cfg.res_offset_mohm[17]}}, i_cfg.res_offset_mohm};

    always_comb begin
        if (w_rsum > 23'sd300000) begin
            w_rclamp = 23'(RES_MAX);
        end else if (w_rsum < -23'sd300000) begin
            w_rclamp = -23'(RES_MAX);
        end else begin
            w_rclamp = w_rsum;
        end
    end

    // Temperature: round half up of product / 2^16, then saturation.
    assign w_tsum = r_prod + 49'sd32768;
    assign w_t    = w_tsum[48:16];

    always_comb begin
        if (w_t > 33'sd2000000) begin
            w_tclamp = 33'(TEMP_MAX);
        end else if (w_t < -33'sd2000000) begin
            w_tclamp = -33'(TEMP_MAX);
        end else begin
            w_tclamp = w_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != B_TEMP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_IDLE: begin
                    if (i_q_avail) begin
                        r_med   <= i_q_data;
                        r_state <= B_MUL_V;
                    end
                end
                B_MUL_V: begin
                    r_prod  <= w_prod[48:0];
                    r_state <= B_VOLT;
                end
                B_VOLT: begin
                    r_volt  <= w_vsum[38:15];
                    r_state <= B_MUL_R;
                end
                B_MUL_R: begin
                    r_prod  <= w_prod[48:0];
                    r_state <= B_SCALE;
                end
                B_SCALE: begin
                    r_rem   <= w_bias[REM_W-1:0];
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_quo   <= w_recip_prod[RES_RECIP_SHIFT+QUO_W-1:RES_RECIP_SHIFT];
                    r_state <= B_RES;
                end
                B_RES: begin
                    r_res   <= w_rclamp[19:0];
                    r_state <= B_MUL_T;
                end
                B_MUL_T: begin
                    r_prod  <= w_prod[48:0];
                    r_state <= B_TEMP;
                end
                B_TEMP: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_med   <= r_med;
                        r_out_volt  <= r_volt;
                        r_out_res   <= r_res;
                        r_out_temp  <= w_tclamp[21:0];
                        r_state     <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/median_rtd_temperature.sv -----
// Top level of the median-filtered RTD thermometer: configuration registers and the
// front end, queue and back end. Depends on mrt_pkg, mrt_front, mrt_fifo and mrt_back.
//
// Each accepted ADC code enters a ring of five codes, and the median of the ring is
// converted to microvolts, a saturated RTD resistance and a saturated temperature. The
// front end takes a code, ranks the ring one element per cycle and then queues the
// median; its input stalls from each accepted code until that median is queued. The
// back end is a sequencer with three passes through one shared multiplier with their
// rounding steps and a division by 1000 done as one multiplication by a reciprocal; it
// takes no new median from the queue until the last result is in the output register.
// A two-entry queue and the output register let either side stall alone. Configuration
// writes are always ready and must only be made while no sample is in flight.
module median_rtd_temperature (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  mrt_pkg::t_code                      i_raw_code,
    output logic                                o_valid,
    input  logic                                i_stall,
    output mrt_pkg::t_code                      o_median_code,
    output mrt_pkg::t_volt                      o_voltage_uv,
    output mrt_pkg::t_res                       o_resistance_mohm,
    output mrt_pkg::t_temp                      o_temperature_mdeg,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mrt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mrt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import mrt_pkg::*;

    t_cfg  r_cfg;
    logic  w_push;
    t_code w_push_data;
    logic  w_full;
    logic  w_pop;
    logic  w_avail;
    t_code w_pop_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_scale_uv   <= RST_FULL_SCALE;
            r_cfg.res_gain_q16    <= RST_RES_GAIN;
            r_cfg.res_offset_mohm <= RST_RES_OFFSET;
            r_cfg.r_zero_mohm     <= RST_R_ZERO;
            r_cfg.inv_sens_q16    <= RST_INV_SENS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_FULL_SCALE: r_cfg.full_scale_uv   <= i_cfg_data[22:0];
                CFG_RES_GAIN:   r_cfg.res_gain_q16    <= i_cfg_data[23:0];
                CFG_RES_OFFSET: r_cfg.res_offset_mohm <= i_cfg_data[17:0];
                CFG_R_ZERO:     r_cfg.r_zero_mohm     <= i_cfg_data[19:0];
                CFG_INV_SENS:   r_cfg.inv_sens_q16    <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    mrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_raw_code  (i_raw_code),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    mrt_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_avail     (w_avail),
        .o_pop_data  (w_pop_data)
    );

    mrt_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_q_avail          (w_avail),
        .i_q_data           (w_pop_data),
        .o_q_pop            (w_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_median_code      (o_median_code),
        .o_voltage_uv       (o_voltage_uv),
        .o_resistance_mohm  (o_resistance_mohm),
        .o_temperature_mdeg (o_temperature_mdeg)
    );

endmodule

// ----- test/median_rtd_temperature_tb.sv -----
// Self-checking testbench for median_rtd_temperature: sends ADC codes and register
// writes, predicts each filtered reading in fixed point and compares every field.
// Depends on mrt_pkg and the RTL of the block, nothing else.
module median_rtd_temperature_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrt_pkg::*;

    typedef struct packed {
        t_code median_code;
        t_volt voltage_uv;
        t_res  resistance_mohm;
        t_temp temperature_mdeg;
    } t_reading;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic                  o_stall;
    t_code                 i_raw_code  = '0;
    logic                  o_valid;
    logic                  i_stall     = 1'b0;
    t_code                 o_median_code;
    t_volt                 o_voltage_uv;
    t_res                  o_resistance_mohm;
    t_temp                 o_temperature_mdeg;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic [22:0]        cfg_full_scale = RST_FULL_SCALE;
    logic [23:0]        cfg_res_gain   = RST_RES_GAIN;
    logic signed [17:0] cfg_res_offset = RST_RES_OFFSET;
    logic [19:0]        cfg_r_zero     = RST_R_ZERO;
    logic [23:0]        cfg_inv_sens   = RST_INV_SENS;

    t_code    code_ring [WINDOW] = '{default: '0};
    int       ring_pos           = 0;
    t_reading pending_readings[$];
    t_code    drift_level        = '0;
    int       mismatch_count     = 0;
    bit       valid_up           = 1'b0;
    bit       send_gaps          = 1'b0;
    bit       stall_bursts       = 1'b0;
    bit       hold_request       = 1'b0;

    median_rtd_temperature dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_raw_code         (i_raw_code),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_median_code      (o_median_code),
        .o_voltage_uv       (o_voltage_uv),
        .o_resistance_mohm  (o_resistance_mohm),
        .o_temperature_mdeg (o_temperature_mdeg),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint round_quot(longint num, longint den);
        longint n;
        longint q;
        n = num + den / 2;
        q = n / den;
        if (n % den != 0 && n < 0) begin
            q--;
        end
        return q;
    endfunction

    function automatic longint saturate(longint v, longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic t_reading predict_reading(t_code code);
        t_code    sorted [WINDOW];
        t_code    key;
        longint   med;
        longint   volt;
        longint   res;
        longint   temp;
        int       j;
        t_reading r;
        code_ring[ring_pos] = code;
        ring_pos = (ring_pos + 1 >= WINDOW) ? 0 : ring_pos + 1;
        sorted = code_ring;
        for (int i = 1; i < WINDOW; i++) begin
            key = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > key) begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        med  = sorted[MED_RANK];
        volt = round_quot(med * longint'(cfg_full_scale), 32768);
        res  = saturate(round_quot(volt * longint'(cfg_res_gain), 65536000)
                        + longint'(cfg_res_offset), RES_MAX);
        temp = saturate(round_quot((res - longint'(cfg_r_zero)) * longint'(cfg_inv_sens),
                                   65536), TEMP_MAX);
        r.median_code      = sorted[MED_RANK];
        r.voltage_uv       = volt[23:0];
        r.resistance_mohm  = res[19:0];
        r.temperature_mdeg = temp[21:0];
        return r;
    endfunction

    function automatic t_code random_code();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_code'($urandom_range(0, 16'hFFFF));
            4:          return $urandom_range(0, 1) ? t_code'(16'h7FFF) : t_code'(16'h8000);
            default: begin
                drift_level = drift_level + t_code'($urandom_range(0, 400)) - t_code'(200);
                return drift_level;
            end
        endcase
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatch_count < 50) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    task automatic drop_valid();
        if (valid_up) begin
            i_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic send_code(t_code code);
        if (send_gaps && $urandom_range(0, 4) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        valid_up   = 1'b1;
        i_raw_code <= code;
        do @(posedge i_clk); while (o_stall);
        pending_readings.push_back(predict_reading(code));
    endtask

    task automatic wait_drained();
        drop_valid();
        while (pending_readings.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FULL_SCALE: cfg_full_scale = data[22:0];
            CFG_RES_GAIN:   cfg_res_gain   = data;
            CFG_RES_OFFSET: cfg_res_offset = data[17:0];
            CFG_R_ZERO:     cfg_r_zero     = data[19:0];
            CFG_INV_SENS:   cfg_inv_sens   = data;
            default: ;
        endcase
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] full_scale, logic [CFG_DATA_W-1:0] gain,
                             logic [CFG_DATA_W-1:0] offset, logic [CFG_DATA_W-1:0] r_zero,
                             logic [CFG_DATA_W-1:0] inv_sens);
        wait_drained();
        write_reg(CFG_FULL_SCALE, full_scale);
        write_reg(CFG_RES_GAIN, gain);
        write_reg(CFG_RES_OFFSET, offset);
        write_reg(CFG_R_ZERO, r_zero);
        write_reg(CFG_INV_SENS, inv_sens);
        i_cfg_valid <= 1'b0;
    endtask

    // The zeros left by reset take part in the first medians.
    task automatic test_startup_window();
        t_code codes [10] = '{16'sd100, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
                              16'sh8000, 16'sh8000, 16'sd0, -16'sd1, 16'sd1};
        foreach (codes[k]) begin
            send_code(codes[k]);
        end
    endtask

    task automatic test_register_extremes();
        configure(24'hFFFFFF, 24'hFFFFFF, 24'h01FFFF, 24'h000000, 24'hFFFFFF);
        repeat (3) send_code(16'sh7FFF);
        configure(24'h000000, 24'hFFFFFF, 24'h020000, 24'hFFFFFF, 24'hFFFFFF);
        repeat (3) send_code(16'sh8000);
        configure(24'd64000, 24'd0, 24'($signed(-100000)), 24'd1000000, 24'd0);
        send_code(16'sh7FFF);
        send_code(-16'sd1234);
        wait_drained();
        for (int idx = CFG_INV_SENS + 1; idx < (1 << CFG_IDX_W); idx++) begin
            write_reg(idx[CFG_IDX_W-1:0], 24'($urandom()));
        end
        i_cfg_valid <= 1'b0;
        send_code(16'sd20000);
        send_code(-16'sd20000);
    endtask

    task automatic test_random_traffic(int phases, int items_per_phase);
        for (int p = 0; p < phases; p++) begin
            case ($urandom_range(0, 3))
                0: configure(24'(RST_FULL_SCALE), RST_RES_GAIN, 24'(RST_RES_OFFSET),
                             24'(RST_R_ZERO), RST_INV_SENS);
                1: configure(24'($urandom_range(64000, 6144000)),
                             24'($urandom_range(2500000, 3800000)),
                             24'($urandom_range(0, 200000) - 100000),
                             24'($urandom_range(80000, 120000)),
                             24'($urandom_range(100000, 250000)));
                2: configure(24'($urandom()), 24'($urandom()), 24'($urandom()),
                             24'($urandom()), 24'($urandom()));
                default: configure(24'($urandom_range(0, 1) ? 64000 : 6144000),
                                   24'($urandom_range(0, 1) ? 0 : 24'hFFFFFF),
                                   24'($urandom_range(0, 1) ? -100000 : 100000),
                                   24'($urandom_range(0, 1) ? 0 : 1000000),
                                   24'($urandom_range(0, 1) ? 0 : 24'hFFFFFF));
            endcase
            send_gaps    = (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            stall_bursts = (p == 0) ? 1'b1 : 1'($urandom_range(0, 1));
            repeat (items_per_phase) send_code(random_code());
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_full_queue_stall();
        send_gaps    = 1'b0;
        stall_bursts = 1'b0;
        wait_drained();
        hold_request = 1'b1;
        repeat (24) send_code(random_code());
        while (hold_request) @(posedge i_clk);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        send_gaps    = 1'b0;
        stall_bursts = 1'b0;
        repeat (30) send_code(random_code());
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
                i_stall <= 1'b0;
                hold_request = 1'b0;
            end else if (stall_bursts && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_result
        t_reading want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_readings.size() == 0) begin
                flag_mismatch("result with no pending request");
            end else begin
                want = pending_readings.pop_front();
                if (o_median_code !== want.median_code)
                    flag_mismatch($sformatf("median_code %0d, expected %0d",
                                            o_median_code, want.median_code));
                if (o_voltage_uv !== want.voltage_uv)
                    flag_mismatch($sformatf("voltage_uv %0d, expected %0d",
                                            o_voltage_uv, want.voltage_uv));
                if (o_resistance_mohm !== want.resistance_mohm)
                    flag_mismatch($sformatf("resistance_mohm %0d, expected %0d",
                                            o_resistance_mohm, want.resistance_mohm));
                if (o_temperature_mdeg !== want.temperature_mdeg)
                    flag_mismatch($sformatf("temperature_mdeg %0d, expected %0d",
                                            o_temperature_mdeg, want.temperature_mdeg));
            end
        end
    end

    initial begin
        #2_000_000;
        $display("median_rtd_temperature_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_startup_window();
        test_register_extremes();
        test_random_traffic(6, 55);
        test_full_queue_stall();
        test_steady_stream();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("median_rtd_temperature_tb OK");
        end else begin
            $display("median_rtd_temperature_tb NOT OK");
        end
        $finish;
    end

endmodule
